### hw/rtl/iffcdf_pkg.sv
// Package for the IFF chunk description finder.
// Holds the item types, parser phases, verdict codes, command format and text table.
// No dependencies.
package iffcdf_pkg;

    localparam logic [31:0] TAG_FORM = 32'h464F_524D;
    localparam logic [31:0] TAG_IFZS = 32'h4946_5A53;
    localparam logic [31:0] TAG_ANNO = 32'h414E_4E4F;

    localparam logic [7:0] MAX_LEN_RESET = 8'd99;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_file;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic [2:0] status;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_CHDR,
        PH_BODY,
        PH_PAD,
        PH_ANNO,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND,
        ST_DEFAULT,
        ST_BAD_IDS,
        ST_BAD_LEN,
        ST_TRUNC,
        ST_OVERRUN,
        ST_TOO_LONG
    } t_status;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Commands from the parser to the emitter.
    typedef enum logic [1:0] {
        CMD_BYTE,       // one description byte
        CMD_BYTE_FOUND, // last description byte, then the found verdict
        CMD_VERDICT,    // verdict only
        CMD_DEFAULT     // default text, then the default verdict
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
        t_status    status;
    } t_cmd;

    typedef enum logic [1:0] {
        SEQ_NONE,
        SEQ_TEXT,
        SEQ_TAIL
    } t_seq;

    function automatic logic [7:0] default_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h55; // U
            4'd1:    c = 8'h6E; // n
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h61; // a
            4'd4:    c = 8'h6D; // m
            4'd5:    c = 8'h65; // e
            4'd6:    c = 8'h64; // d
            4'd7:    c = 8'h20; // space
            4'd8:    c = 8'h53; // S
            4'd9:    c = 8'h61; // a
            4'd10:   c = 8'h76; // v
            4'd11:   c = 8'h65; // e
            4'd12:   c = 8'h67; // g
            4'd13:   c = 8'h61; // a
            4'd14:   c = 8'h6D; // m
            default: c = 8'h65; // e
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/iff_chunk_description_finder_top.sv
// IFF save-file description finder, top level.
// Instantiates iffcdf_front, iffcdf_queue and iffcdf_back; types from iffcdf_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready / i_in) takes one file byte per item; set
//   first_of_file on the first byte of each file to restart the parse.
//   Output channel (o_valid / i_ready / o_out) gives description bytes
//   (kind 0) and then one verdict item (kind 1, last 1) per file.
//   i_cfg_we / i_cfg_data write the largest accepted description length.
// Throughput: one input item per cycle; the parser does one byte per cycle
//   with one subtract-and-compare per byte. One output item per cycle while
//   i_ready holds; a default-text command expands to 17 items in the emitter,
//   so the input stalls once the 4-entry command queue fills behind it.
// Path: a result is written to a queue entry, then to the emitter output register.
// Reset: synchronous, active low; parser returns to idle (bytes ignored until
//   first_of_file), queue and output register empty, length limit back to 99.
// Receiver stall: hold the output item in its register, fill the queue, then
//   drop o_ready until room opens up again.
module iff_chunk_description_finder_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  iffcdf_pkg::t_in_item  i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output iffcdf_pkg::t_out_item o_out
);

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    iffcdf_pkg::t_cmd q_wr_cmd;
    iffcdf_pkg::t_cmd q_head;

    // Front: header and chunk walk, one command per byte at most.
    iffcdf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_wr_cmd)
    );

    // Queue: decouples parsing from result delivery.
    iffcdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: expand commands into items, one per cycle while the receiver is ready.
    iffcdf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

endmodule

### hw/rtl/iffcdf_front.sv
// Parser front end: accepts file bytes, walks the IFF headers and issues commands.
// Holds the length limit register. Depends on iffcdf_pkg.
module iffcdf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  iffcdf_pkg::t_in_item i_in,
    input  logic                 i_q_full,
    output logic                 o_push,
    output iffcdf_pkg::t_cmd     o_cmd
);

    iffcdf_pkg::t_phase r_phase, n_phase;
    logic [3:0]         r_cnt, n_cnt;
    logic [31:0]        r_id, n_id;
    logic               r_form_ok, n_form_ok;
    logic [31:0]        r_form, n_form;
    logic [31:0]        r_chunk, n_chunk;
    logic               r_pad, n_pad;
    logic [7:0]         r_max_len;

    logic               accept;
    logic [7:0]         b;
    iffcdf_pkg::t_phase eff_phase;
    logic [3:0]         eff_cnt;
    logic [31:0]        id_next;
    logic [31:0]        chunk_full;
    logic [33:0]        diff;
    logic               do_next;
    logic [31:0]        nc_form;
    logic               cmd_valid;
    iffcdf_pkg::t_cmd   cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_in.data_byte;
    assign o_push  = accept && cmd_valid;
    assign o_cmd   = cmd;

    assign eff_phase  = i_in.first_of_file ? iffcdf_pkg::PH_HDR : r_phase;
    assign eff_cnt    = i_in.first_of_file ? 4'd0 : r_cnt;
    assign id_next    = {r_id[23:0], b};
    assign chunk_full = {r_chunk[23:0], b};
    // Remaining form after this chunk's body and pad byte; bit 33 flags an overrun.
    assign diff = {2'b00, r_form} - {2'b00, chunk_full} - {33'd0, b[0]};

    always_comb begin
        n_phase   = eff_phase;
        n_cnt     = eff_cnt + 4'd1;
        n_id      = r_id;
        n_form_ok = r_form_ok;
        n_form    = r_form;
        n_chunk   = r_chunk;
        n_pad     = r_pad;
        do_next   = 1'b0;
        nc_form   = r_form;
        cmd_valid = 1'b0;
        cmd       = '{op: iffcdf_pkg::CMD_VERDICT, data: 8'd0, status: iffcdf_pkg::ST_FOUND};

        case (eff_phase)
            iffcdf_pkg::PH_HDR: begin
                if (eff_cnt < 4'd4 || eff_cnt >= 4'd8) begin
                    n_id = id_next;
                end else begin
                    n_form = {r_form[23:0], b};
                end
                if (eff_cnt == 4'd3) begin
                    n_form_ok = (id_next == iffcdf_pkg::TAG_FORM);
                end
                if (eff_cnt == 4'd11) begin
                    cmd_valid = 1'b1;
                    n_phase   = iffcdf_pkg::PH_DONE;
                    if (!(r_form_ok && id_next == iffcdf_pkg::TAG_IFZS)) begin
                        cmd.status = iffcdf_pkg::ST_BAD_IDS;
                    end else if (r_form[0] || r_form < 32'd4) begin
                        cmd.status = iffcdf_pkg::ST_BAD_LEN;
                    end else begin
                        // Drop the form type from the count, then look for the first chunk if its header fits.
                        n_form = r_form - 32'd4;
                        if (r_form == 32'd4) begin
                            cmd.op = iffcdf_pkg::CMD_DEFAULT;
                        end else if (r_form < 32'd12) begin
                            cmd.status = iffcdf_pkg::ST_TRUNC;
                        end else begin
                            cmd_valid = 1'b0;
                            n_phase   = iffcdf_pkg::PH_CHDR;
                            n_cnt     = 4'd0;
                        end
                    end
                end
            end
            iffcdf_pkg::PH_CHDR: begin
                if (eff_cnt < 4'd4) begin
                    n_id = id_next;
                end else begin
                    n_chunk = chunk_full;
                end
                // Charge the 8 header bytes up front; at least 8 remain here.
                if (eff_cnt == 4'd0) begin
                    n_form = r_form - 32'd8;
                end
                if (eff_cnt == 4'd7) begin
                    n_pad = b[0];
                    if (diff[33]) begin
                        cmd_valid  = 1'b1;
                        cmd.status = iffcdf_pkg::ST_OVERRUN;
                        n_phase    = iffcdf_pkg::PH_DONE;
                    end else begin
                        n_form = diff[31:0];
                        if (r_id == iffcdf_pkg::TAG_ANNO) begin
                            if (chunk_full > {24'd0, r_max_len}) begin
                                cmd_valid  = 1'b1;
                                cmd.status = iffcdf_pkg::ST_TOO_LONG;
                                n_phase    = iffcdf_pkg::PH_DONE;
                            end else if (chunk_full == 32'd0) begin
                                cmd_valid  = 1'b1;
                                cmd.status = iffcdf_pkg::ST_FOUND;
                                n_phase    = iffcdf_pkg::PH_DONE;
                            end else begin
                                n_phase = iffcdf_pkg::PH_ANNO;
                            end
                        end else if (chunk_full != 32'd0) begin
                            n_phase = iffcdf_pkg::PH_BODY;
                        end else begin
                            do_next = 1'b1;
                            nc_form = diff[31:0];
                        end
                    end
                end
            end
            iffcdf_pkg::PH_BODY: begin
                n_chunk = r_chunk - 32'd1;
                if (r_chunk == 32'd1) begin
                    if (r_pad) begin
                        n_phase = iffcdf_pkg::PH_PAD;
                    end else begin
                        do_next = 1'b1;
                    end
                end
            end
            iffcdf_pkg::PH_PAD: begin
                n_pad   = 1'b0;
                do_next = 1'b1;
            end
            iffcdf_pkg::PH_ANNO: begin
                cmd_valid = 1'b1;
                cmd.op    = iffcdf_pkg::CMD_BYTE;
                cmd.data  = b;
                n_chunk   = r_chunk - 32'd1;
                if (r_chunk == 32'd1) begin
                    cmd.op  = iffcdf_pkg::CMD_BYTE_FOUND;
                    n_phase = iffcdf_pkg::PH_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
                n_cnt   = r_cnt;
            end
        endcase

        // Start of the next chunk header, the end of the form, or a truncated form.
        if (do_next) begin
            if (nc_form == 32'd0) begin
                cmd_valid = 1'b1;
                cmd.op    = iffcdf_pkg::CMD_DEFAULT;
                n_phase   = iffcdf_pkg::PH_DONE;
            end else if (nc_form < 32'd8) begin
                cmd_valid  = 1'b1;
                cmd.status = iffcdf_pkg::ST_TRUNC;
                n_phase    = iffcdf_pkg::PH_DONE;
            end else begin
                n_phase = iffcdf_pkg::PH_CHDR;
                n_cnt   = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= iffcdf_pkg::PH_IDLE;
            r_cnt     <= 4'd0;
            r_form_ok <= 1'b0;
            r_pad     <= 1'b0;
            r_max_len <= iffcdf_pkg::MAX_LEN_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_cnt     <= n_cnt;
                r_form_ok <= n_form_ok;
                r_pad     <= n_pad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id    <= n_id;
            r_form  <= n_form;
            r_chunk <= n_chunk;
        end
    end

endmodule

### hw/rtl/iffcdf_queue.sv
// Short command queue between the parser and the emitter.
// Register-based FIFO of iffcdf_pkg::t_cmd entries. Depends on iffcdf_pkg.
module iffcdf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  iffcdf_pkg::t_cmd i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output iffcdf_pkg::t_cmd o_head
);

    iffcdf_pkg::t_cmd                  r_mem [iffcdf_pkg::QUEUE_DEPTH];
    logic [iffcdf_pkg::QUEUE_AW-1:0]   r_wr, r_rd;
    logic [iffcdf_pkg::QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (iffcdf_pkg::QUEUE_AW+1)'(iffcdf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### hw/rtl/iffcdf_back.sv
// Emitter back end: expands queued commands into result items.
// Drives the registered output channel. Depends on iffcdf_pkg.
module iffcdf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  iffcdf_pkg::t_cmd      i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output iffcdf_pkg::t_out_item o_out
);

    iffcdf_pkg::t_seq      r_seq, n_seq;
    logic [3:0]            r_idx, n_idx;
    iffcdf_pkg::t_status   r_tail, n_tail;
    logic                  r_ov;
    iffcdf_pkg::t_out_item r_out;

    logic                  load;
    logic                  gen_valid;
    iffcdf_pkg::t_out_item gen;

    assign load    = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_out   = r_out;

    always_comb begin
        n_seq     = r_seq;
        n_idx     = r_idx;
        n_tail    = r_tail;
        o_pop     = 1'b0;
        gen_valid = 1'b0;
        gen       = '{out_byte: 8'd0, kind: iffcdf_pkg::KIND_CHAR, status: 3'd0, last: 1'b0};
        if (load) begin
            case (r_seq)
                iffcdf_pkg::SEQ_TEXT: begin
                    gen_valid    = 1'b1;
                    gen.out_byte = iffcdf_pkg::default_char(r_idx);
                    n_idx        = r_idx + 4'd1;
                    if (r_idx == 4'd15) begin
                        n_seq  = iffcdf_pkg::SEQ_TAIL;
                        n_tail = iffcdf_pkg::ST_DEFAULT;
                    end
                end
                iffcdf_pkg::SEQ_TAIL: begin
                    gen_valid  = 1'b1;
                    gen.kind   = iffcdf_pkg::KIND_VERDICT;
                    gen.status = r_tail;
                    gen.last   = 1'b1;
                    n_seq      = iffcdf_pkg::SEQ_NONE;
                end
                default: begin
                    if (!i_empty) begin
                        o_pop     = 1'b1;
                        gen_valid = 1'b1;
                        case (i_head.op)
                            iffcdf_pkg::CMD_BYTE: begin
                                gen.out_byte = i_head.data;
                            end
                            iffcdf_pkg::CMD_BYTE_FOUND: begin
                                gen.out_byte = i_head.data;
                                n_seq        = iffcdf_pkg::SEQ_TAIL;
                                n_tail       = iffcdf_pkg::ST_FOUND;
                            end
                            iffcdf_pkg::CMD_DEFAULT: begin
                                gen.out_byte = iffcdf_pkg::default_char(4'd0);
                                n_seq        = iffcdf_pkg::SEQ_TEXT;
                                n_idx        = 4'd1;
                            end
                            default: begin
                                gen.kind   = iffcdf_pkg::KIND_VERDICT;
                                gen.status = i_head.status;
                                gen.last   = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= iffcdf_pkg::SEQ_NONE;
            r_idx <= 4'd0;
            r_ov  <= 1'b0;
        end else begin
            r_seq <= n_seq;
            r_idx <= n_idx;
            if (load) begin
                r_ov <= gen_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
        if (load && gen_valid) begin
            r_out <= gen;
        end
    end

endmodule
